### src/turtle_3d_segment_interpreter_assert.svh
// assertion macros shared by the turtle interpreter modules
// no dependencies; included by modules that carry concurrent checks
`ifndef TURTLE_3D_SEGMENT_INTERPRETER_ASSERT_SVH
`define TURTLE_3D_SEGMENT_INTERPRETER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TDSI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TDSI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tdsi_pkg.sv
// shared types, symbol codes and constants for the 3d turtle interpreter
// no dependencies
package tdsi_pkg;

  localparam int STACK_DEPTH_DEF = 16;

  localparam int ROT_W      = 18;
  localparam int POS_W      = 32;
  localparam int STEP_W     = 31;
  localparam int SYM_W      = 8;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // q1.16 one and zero
  localparam logic [ROT_W-1:0] ONE_Q16  = 18'd65536;
  localparam logic [ROT_W-1:0] ROT_ZERO = 18'd0;

  // turtle command characters
  localparam logic [SYM_W-1:0] SYM_FWD   = 8'h46; // F
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B; // +
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D; // -
  localparam logic [SYM_W-1:0] SYM_CARET = 8'h5E; // ^
  localparam logic [SYM_W-1:0] SYM_AMP   = 8'h26; // &
  localparam logic [SYM_W-1:0] SYM_LT    = 8'h3C; // <
  localparam logic [SYM_W-1:0] SYM_GT    = 8'h3E; // >
  localparam logic [SYM_W-1:0] SYM_BAR   = 8'h7C; // | (half turn about y)
  localparam logic [SYM_W-1:0] SYM_PUSH  = 8'h5B; // [
  localparam logic [SYM_W-1:0] SYM_POP   = 8'h5D; // ]

  // result kinds
  localparam logic [KIND_W-1:0] KIND_NONE      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEGMENT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UNDERFLOW = 2'd2;
  localparam logic [KIND_W-1:0] KIND_OVERFLOW  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIN  = 2'd2;

  // rotation stored by column: entry col*3+row
  typedef struct packed {
    logic [8:0][ROT_W-1:0] rot;
    logic [2:0][POS_W-1:0] pos;
  } frame_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stk_status_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_op_t;

  localparam frame_t FRAME_INIT = '{
    rot: {ONE_Q16, {3{ROT_ZERO}}, ONE_Q16, {3{ROT_ZERO}}, ONE_Q16},
    pos: '0
  };

endpackage

### src/tdsi_frame_math.sv
// next-frame and result logic for one turtle symbol
// depends on tdsi_pkg
module tdsi_frame_math import tdsi_pkg::*; (
  input  logic [SYM_W-1:0]         symbol,
  input  frame_t                   frame,
  input  frame_t                   top,
  input  stk_status_t              stat,
  input  logic [STEP_W-1:0]        step_length,
  input  logic signed [ROT_W-1:0]  cos_angle,
  input  logic signed [ROT_W-1:0]  sin_angle,
  output frame_t                   frame_next,
  output stk_op_t                  op,
  output logic [KIND_W-1:0]        kind,
  output logic [2:0][POS_W-1:0]    start_pos,
  output logic [2:0][POS_W-1:0]    end_pos
);

  // rounding half up to q1.16 and clamping to plus or minus one
  function automatic logic [ROT_W-1:0] rnd_clamp(input logic signed [37:0] v);
    logic signed [37:0] b;
    logic signed [37:0] sh;
    logic [ROT_W-1:0]   r;
    b  = v + 38'sd32768;
    sh = b >>> 16;
    if (sh > 38'sd65536) begin
      r = 18'd65536;
    end else if (sh < -38'sd65536) begin
      r = 18'h30000;
    end else begin
      r = sh[ROT_W-1:0];
    end
    return r;
  endfunction

  // decode of the turn symbols
  logic is_mix;
  logic is_half;
  logic is_fwd;
  logic p_is1;   // first column of the pair is 1, else 0
  logic q_is2;   // second column of the pair is 2, else 1
  logic neg_s;

  always_comb begin
    is_mix  = 1'b0;
    is_half = 1'b0;
    is_fwd  = 1'b0;
    p_is1   = 1'b0;
    q_is2   = 1'b0;
    neg_s   = 1'b0;
    unique case (symbol)
      SYM_FWD: begin
        is_fwd = 1'b1;
      end
      SYM_PLUS: begin
        is_mix = 1'b1;
        p_is1  = 1'b1;
        q_is2  = 1'b1;
      end
      SYM_MINUS: begin
        is_mix = 1'b1;
        p_is1  = 1'b1;
        q_is2  = 1'b1;
        neg_s  = 1'b1;
      end
      SYM_CARET: begin
        is_mix = 1'b1;
      end
      SYM_AMP: begin
        is_mix = 1'b1;
        neg_s  = 1'b1;
      end
      SYM_LT: begin
        is_mix = 1'b1;
        q_is2  = 1'b1;
        neg_s  = 1'b1;
      end
      SYM_GT: begin
        is_mix = 1'b1;
        q_is2  = 1'b1;
      end
      SYM_BAR: begin
        is_half = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // signed cosine and the signed sine term of the pair rotation
  logic signed [ROT_W:0] c19;
  logic signed [ROT_W:0] s19;
  logic signed [ROT_W:0] t19;

  assign c19 = {cos_angle[ROT_W-1], cos_angle};
  assign s19 = {sin_angle[ROT_W-1], sin_angle};
  assign t19 = neg_s ? -s19 : s19;

  // per-row products: new p = c*xp + t*xq, new q = c*xq - t*xp
  logic signed [ROT_W-1:0] xp     [3];
  logic signed [ROT_W-1:0] xq     [3];
  logic signed [36:0]      p_cp   [3];
  logic signed [36:0]      p_tq   [3];
  logic signed [36:0]      p_tp   [3];
  logic signed [36:0]      p_cq   [3];
  logic [ROT_W-1:0]        new_p  [3];
  logic [ROT_W-1:0]        new_q  [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      xp[r]    = $signed(p_is1 ? frame.rot[3 + r] : frame.rot[r]);
      xq[r]    = $signed(q_is2 ? frame.rot[6 + r] : frame.rot[3 + r]);
      p_cp[r]  = c19 * xp[r];
      p_tq[r]  = t19 * xq[r];
      p_tp[r]  = t19 * xp[r];
      p_cq[r]  = c19 * xq[r];
      new_p[r] = rnd_clamp(38'(p_cp[r]) + 38'(p_tq[r]));
      new_q[r] = rnd_clamp(38'(p_cq[r]) - 38'(p_tp[r]));
    end
  end

  // forward move along column 1, rounded and saturated
  logic signed [POS_W-1:0] step_s;
  logic signed [49:0]      mv_prod [3];
  logic signed [49:0]      mv_d    [3];
  logic signed [50:0]      mv_sum  [3];
  logic [POS_W-1:0]        mv_pos  [3];

  assign step_s = $signed({1'b0, step_length});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mv_prod[i] = $signed(frame.rot[3 + i]) * step_s;
      mv_d[i]    = (mv_prod[i] + 50'sd32768) >>> 16;
      mv_sum[i]  = 51'($signed(frame.pos[i])) + 51'(mv_d[i]);
      if (mv_sum[i] > 51'sd2147483647) begin
        mv_pos[i] = 32'h7FFF_FFFF;
      end else if (mv_sum[i] < -51'sd2147483648) begin
        mv_pos[i] = 32'h8000_0000;
      end else begin
        mv_pos[i] = mv_sum[i][POS_W-1:0];
      end
    end
  end

  // assemble next frame, stack request and result
  always_comb begin
    frame_next = frame;
    op         = '0;
    kind       = KIND_NONE;
    start_pos  = '0;
    end_pos    = '0;
    if (is_fwd) begin
      kind = KIND_SEGMENT;
      for (int i = 0; i < 3; i++) begin
        start_pos[i]      = frame.pos[i];
        end_pos[i]        = mv_pos[i];
        frame_next.pos[i] = mv_pos[i];
      end
    end else if (is_mix) begin
      for (int r = 0; r < 3; r++) begin
        if (p_is1) begin
          frame_next.rot[3 + r] = new_p[r];
        end else begin
          frame_next.rot[r] = new_p[r];
        end
        if (q_is2) begin
          frame_next.rot[6 + r] = new_q[r];
        end else begin
          frame_next.rot[3 + r] = new_q[r];
        end
      end
    end else if (is_half) begin
      // exact negation of columns 0 and 2
      for (int r = 0; r < 3; r++) begin
        frame_next.rot[r]     = -frame.rot[r];
        frame_next.rot[6 + r] = -frame.rot[6 + r];
      end
    end else if (symbol == SYM_PUSH) begin
      if (stat.full) begin
        kind = KIND_OVERFLOW;
      end else begin
        op.push = 1'b1;
      end
    end else if (symbol == SYM_POP) begin
      if (stat.empty) begin
        kind = KIND_UNDERFLOW;
      end else begin
        op.pop     = 1'b1;
        frame_next = top;
      end
    end
  end

endmodule

### src/tdsi_stack.sv
// frame stack: memory of saved frames with the top and the entry below kept in registers
// depends on tdsi_pkg and turtle_3d_segment_interpreter_assert.svh
`include "turtle_3d_segment_interpreter_assert.svh"

module tdsi_stack import tdsi_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  stk_op_t     op,
  input  frame_t      push_frame,
  output frame_t      top_frame,
  output stk_status_t stat
);

  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  frame_t        mem [STACK_DEPTH];
  logic [LW-1:0] level;
  logic [LW-1:0] level_next;
  logic [LW-1:0] rd_level;
  frame_t        top;
  frame_t        below;

  assign stat.empty = (level == '0);
  assign stat.full  = (level == LW'(STACK_DEPTH));
  assign top_frame  = top;

  // fill level
  always_comb begin
    level_next = level;
    if (op.push) begin
      level_next = level + LW'(1);
    end else if (op.pop) begin
      level_next = level - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else begin
      level <= level_next;
    end
  end

  // memory write on push; read of the entry that sits below the next top
  assign rd_level = level_next - LW'(2);

  always_ff @(posedge clk) begin
    if (op.push) begin
      mem[level[AW-1:0]] <= push_frame;
    end
    below <= mem[rd_level[AW-1:0]];
  end

  // top of stack register
  always_ff @(posedge clk) begin
    if (op.push) begin
      top <= push_frame;
    end else if (op.pop) begin
      top <= below;
    end
  end

  `TDSI_ASSERT_NOW(a_push_not_full, clk, rst, op.push, !stat.full, "push into a full stack")
  `TDSI_ASSERT_NOW(a_pop_not_empty, clk, rst, op.pop, !stat.empty, "pop from an empty stack")
  `TDSI_ASSERT_NEXT(a_push_level, clk, rst, op.push, level == $past(level) + LW'(1), "bad level")

endmodule

### src/turtle_3d_segment_interpreter.sv
// 3d turtle interpreter for l-system symbols, one symbol per request
// Usage:
//   cfg channel (cfg_valid/cfg_ready, always ready) writes step_length (index 0),
//   cos_angle (1) and sin_angle (2); write only while the block is idle.
//   input channel (in_valid/in_stall) takes one ascii symbol per request.
//   output channel (out_valid/out_stall) gives exactly one result per symbol:
//   result_kind plus segment start and end for F, zero coordinates otherwise.
// Timing:
//   a symbol lands in the input register; when the result register can take it,
//   the frame logic updates the turtle state and loads the result register.
//   one symbol per cycle sustained while out_stall is low, with the frame
//   update (multiplies, adder) combinational into the frame register.
// Reset:
//   frame is identity rotation at the origin, stack empty, step_length one,
//   cos_angle one, sin_angle zero; both pipeline registers empty.
// Stall:
//   while out_stall holds a result, one more symbol is taken into the input
//   register, then in_stall rises until the result drains.
// depends on tdsi_pkg, tdsi_frame_math, tdsi_stack and the assert header
`include "turtle_3d_segment_interpreter_assert.svh"

module turtle_3d_segment_interpreter import tdsi_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SYM_W-1:0]        symbol,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [KIND_W-1:0]       result_kind,
  output logic signed [POS_W-1:0] start_x,
  output logic signed [POS_W-1:0] start_y,
  output logic signed [POS_W-1:0] start_z,
  output logic signed [POS_W-1:0] end_x,
  output logic signed [POS_W-1:0] end_y,
  output logic signed [POS_W-1:0] end_z
);

  // configuration registers
  logic [STEP_W-1:0]       step_length;
  logic signed [ROT_W-1:0] cos_angle;
  logic signed [ROT_W-1:0] sin_angle;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_length <= STEP_W'(65536);
      cos_angle   <= ONE_Q16;
      sin_angle   <= ROT_ZERO;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STEP: step_length <= cfg_data[STEP_W-1:0];
        REG_COS:  cos_angle   <= cfg_data[ROT_W-1:0];
        REG_SIN:  sin_angle   <= cfg_data[ROT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // pipeline handshake
  logic             s1_valid;
  logic [SYM_W-1:0] s1_symbol;
  logic             s2_ready;
  logic             fire;

  assign s2_ready = !out_valid || !out_stall;
  assign fire     = s1_valid && s2_ready;
  assign in_stall = s1_valid && !s2_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_symbol <= symbol;
    end
  end

  // turtle frame and stack
  frame_t              frame;
  frame_t              frame_next;
  frame_t              top_frame;
  stk_status_t         stat;
  stk_op_t             op;
  stk_op_t             op_fire;
  logic [KIND_W-1:0]   kind;
  logic [2:0][POS_W-1:0] start_pos;
  logic [2:0][POS_W-1:0] end_pos;

  tdsi_frame_math u_math (
    .symbol      (s1_symbol),
    .frame       (frame),
    .top         (top_frame),
    .stat        (stat),
    .step_length (step_length),
    .cos_angle   (cos_angle),
    .sin_angle   (sin_angle),
    .frame_next  (frame_next),
    .op          (op),
    .kind        (kind),
    .start_pos   (start_pos),
    .end_pos     (end_pos)
  );

  assign op_fire.push = fire && op.push;
  assign op_fire.pop  = fire && op.pop;

  tdsi_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk        (clk),
    .rst        (rst),
    .op         (op_fire),
    .push_frame (frame),
    .top_frame  (top_frame),
    .stat       (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame <= FRAME_INIT;
    end else if (fire) begin
      frame <= frame_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= fire || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_kind <= kind;
      start_x     <= start_pos[0];
      start_y     <= start_pos[1];
      start_z     <= start_pos[2];
      end_x       <= end_pos[0];
      end_y       <= end_pos[1];
      end_z       <= end_pos[2];
    end
  end

  // terms of the result check
  logic non_seg;
  logic no_coords;

  assign non_seg   = out_valid && (result_kind != KIND_SEGMENT);
  assign no_coords = (start_x == '0) && (start_y == '0) && (start_z == '0) &&
                     (end_x == '0) && (end_y == '0) && (end_z == '0);

  `TDSI_ASSERT_NOW(a_no_seg_zero, clk, rst, non_seg, no_coords, "coordinates on a non-segment")

endmodule
